### hw/rtl/sspq_pkg.sv
// ----------------------------------------------------------------------------
// sspq_pkg
// Shared types and constants for the stable sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sspq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int PRIO_W       = 16;
  localparam int ENTRY_W      = VALUE_W + PRIO_W;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PEEK    = 2'd2,
    OP_LIST    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_RD,
    S_ENQ_CMP,
    S_ENQ_PUT,
    S_RD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic signed [PRIO_W-1:0]  prio;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic                      valid;
    status_t                   status;
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
    logic                      last;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/stable_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Bounded priority queue, ascending priority, ties in arrival order.
// ----------------------------------------------------------------------------
// Full enqueue or empty dequeue/peek/list: result in the cycle after start,
//   busy stays low. Enqueue into empty queue: S_ENQ_PUT. Enqueue that moves k
//   entries: S_ENQ_RD (read), S_ENQ_CMP (compare) per entry; S_ENQ_PUT if all.
// Dequeue/peek: S_RD then S_EMIT; list of n entries: S_RD, S_EMIT per entry.
// busy falls in the cycle the final result strobes; results cannot be stalled.
// Reset clears count, head and sequencer; entry store needs no clearing.
`default_nettype none

module stable_sorted_priority_queue #(
  parameter int CAPACITY = sspq_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          in_operation,
  input  wire logic signed [sspq_pkg::VALUE_W-1:0] in_value,
  input  wire logic signed [sspq_pkg::PRIO_W-1:0]  in_priority_req,
  output logic                                     out_valid,
  output logic [1:0]                               out_status,
  output logic signed [sspq_pkg::VALUE_W-1:0]      out_value_res,
  output logic signed [sspq_pkg::PRIO_W-1:0]       out_priority_res,
  output logic                                     out_last
);

  localparam int AW = $clog2(CAPACITY);

  sspq_pkg::res_t res;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [sspq_pkg::ENTRY_W-1:0]  wr_data;
  logic [AW-1:0]                 rd_addr;
  logic [sspq_pkg::ENTRY_W-1:0]  rd_data;

  logic                                out_valid_r;
  logic [1:0]                          out_status_r;
  logic signed [sspq_pkg::VALUE_W-1:0] out_value_r;
  logic signed [sspq_pkg::PRIO_W-1:0]  out_prio_r;
  logic                                out_last_r;

  sspq_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .op      (in_operation),
    .value   (in_value),
    .prio    (in_priority_req),
    .busy    (busy),
    .res     (res),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sspq_ram #(
    .WIDTH(sspq_pkg::ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result register: one-cycle strobe per transaction result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.valid;
    end
    out_status_r <= res.status;
    out_value_r  <= res.value;
    out_prio_r   <= res.prio;
    out_last_r   <= res.last;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_value_res    = out_value_r;
  assign out_priority_res = out_prio_r;
  assign out_last         = out_last_r;

endmodule

`default_nettype wire

### hw/rtl/sspq_ram.sv
// ----------------------------------------------------------------------------
// sspq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sspq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### hw/rtl/sspq_ctrl.sv
// ----------------------------------------------------------------------------
// sspq_ctrl
// Sequencer: circular sorted store, one compare per step for insertion,
// one read per reported entry.
// ----------------------------------------------------------------------------
`default_nettype none

module sspq_ctrl #(
  parameter int CAPACITY = sspq_pkg::CAPACITY_DEF,
  localparam int AW      = $clog2(CAPACITY),
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  input  wire logic [1:0]                            op,
  input  wire logic signed [sspq_pkg::VALUE_W-1:0]   value,
  input  wire logic signed [sspq_pkg::PRIO_W-1:0]    prio,
  output logic                                       busy,
  output sspq_pkg::res_t                             res,
  output logic                                       wr_en,
  output logic [AW-1:0]                              wr_addr,
  output logic [sspq_pkg::ENTRY_W-1:0]               wr_data,
  output logic [AW-1:0]                              rd_addr,
  input  wire logic [sspq_pkg::ENTRY_W-1:0]          rd_data
);

  localparam logic [AW:0]   CAP_X = (AW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  sspq_pkg::state_t state_r, state_nxt;
  sspq_pkg::op_t    op_r, op_nxt;
  logic signed [sspq_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic signed [sspq_pkg::PRIO_W-1:0]  pri_r, pri_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt;

  sspq_pkg::entry_t rd_entry;
  sspq_pkg::entry_t new_entry;
  logic             emit_last;

  assign rd_entry  = rd_data;
  assign new_entry = '{prio: pri_r, value: val_r};

  // logical position behind head -> physical address, wrapping at CAPACITY
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [AW-1:0] lidx);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, lidx};
    if (sum >= CAP_X) begin
      sum = sum - CAP_X;
    end
    return sum[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sspq_pkg::S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
    op_r  <= op_nxt;
    val_r <= val_nxt;
    pri_r <= pri_nxt;
    idx_r <= idx_nxt;
  end

  assign busy      = (state_r != sspq_pkg::S_IDLE);
  assign emit_last = (op_r != sspq_pkg::OP_LIST) || (CW'(idx_r) == count_r - CW'(1));

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    val_nxt   = val_r;
    pri_nxt   = pri_r;
    head_nxt  = head_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_addr   = phys(head_r, idx_r);
    wr_data   = new_entry;
    rd_addr   = phys(head_r, idx_r);
    res       = '{valid: 1'b0, status: sspq_pkg::ST_OK, value: '0, prio: '0, last: 1'b1};

    case (state_r)
      sspq_pkg::S_IDLE: begin
        if (start) begin
          op_nxt  = sspq_pkg::op_t'(op);
          val_nxt = value;
          pri_nxt = prio;
          if (sspq_pkg::op_t'(op) == sspq_pkg::OP_ENQUEUE) begin
            if (count_r == CAP_C) begin
              res.valid  = 1'b1;
              res.status = sspq_pkg::ST_OVER;
            end else if (count_r == '0) begin
              idx_nxt   = '0;
              state_nxt = sspq_pkg::S_ENQ_PUT;
            end else begin
              idx_nxt   = count_r[AW-1:0];
              state_nxt = sspq_pkg::S_ENQ_RD;
            end
          end else if (count_r == '0) begin
            res.valid  = 1'b1;
            res.status = sspq_pkg::ST_UNDER;
          end else begin
            idx_nxt   = '0;
            state_nxt = sspq_pkg::S_RD;
          end
        end
      end

      sspq_pkg::S_ENQ_RD: begin
        rd_addr   = phys(head_r, idx_r - AW'(1));
        state_nxt = sspq_pkg::S_ENQ_CMP;
      end

      sspq_pkg::S_ENQ_CMP: begin
        wr_en = 1'b1;
        if (rd_entry.prio > pri_r) begin
          // move the larger entry one slot back
          wr_data = rd_entry;
          idx_nxt = idx_r - AW'(1);
          if (idx_r == AW'(1)) begin
            state_nxt = sspq_pkg::S_ENQ_PUT;
          end else begin
            state_nxt = sspq_pkg::S_ENQ_RD;
          end
        end else begin
          count_nxt = count_r + CW'(1);
          res.valid = 1'b1;
          state_nxt = sspq_pkg::S_IDLE;
        end
      end

      sspq_pkg::S_ENQ_PUT: begin
        wr_en     = 1'b1;
        count_nxt = count_r + CW'(1);
        res.valid = 1'b1;
        state_nxt = sspq_pkg::S_IDLE;
      end

      sspq_pkg::S_RD: begin
        state_nxt = sspq_pkg::S_EMIT;
      end

      sspq_pkg::S_EMIT: begin
        res.valid = 1'b1;
        res.value = rd_entry.value;
        res.prio  = rd_entry.prio;
        res.last  = emit_last;
        if (emit_last) begin
          if (op_r == sspq_pkg::OP_DEQUEUE) begin
            head_nxt  = phys(head_r, AW'(1));
            count_nxt = count_r - CW'(1);
          end
          state_nxt = sspq_pkg::S_IDLE;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = sspq_pkg::S_RD;
        end
      end

      default: begin
        state_nxt = sspq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### bench/stable_sorted_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_tb
// Drives enqueue, dequeue, peek and list commands into the sorted queue and
// checks every strobed result against a queue model kept in the bench.
// ----------------------------------------------------------------------------

module stable_sorted_priority_queue_tb;

  localparam int CAP      = sspq_pkg::CAPACITY_DEF;
  localparam int TAIL_CYC = 40;

  typedef logic signed [sspq_pkg::VALUE_W-1:0] value_t;
  typedef logic signed [sspq_pkg::PRIO_W-1:0]  prio_t;

  typedef struct packed {
    sspq_pkg::status_t status;
    value_t            value;
    prio_t             prio;
    logic              last;
  } queue_res_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  sspq_pkg::op_t   cmd_op = sspq_pkg::OP_ENQUEUE;
  value_t          cmd_value = '0;
  prio_t           cmd_prio = '0;

  logic            busy;
  logic            out_valid;
  logic [1:0]      out_status;
  value_t          out_value_res;
  prio_t           out_priority_res;
  logic            out_last;

  // bench copy of the queue contents
  value_t model_value [CAP];
  prio_t  model_prio  [CAP];
  int     model_count = 0;

  queue_res_t pending_results[$];

  bit steady = 1'b0;
  int mismatches = 0;
  int results_checked = 0;
  int op_count [4] = '{0, 0, 0, 0};
  int overflows = 0;
  int underflows = 0;
  int max_depth = 0;

  stable_sorted_priority_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (cmd_op),
    .in_value         (cmd_value),
    .in_priority_req  (cmd_prio),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_value_res    (out_value_res),
    .out_priority_res (out_priority_res),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Expected results of one command; updates the bench queue.
  task automatic predict_queue_results(input sspq_pkg::op_t op, input value_t val,
                                       input prio_t pri);
    int pos;
    queue_res_t r;
    r.status = sspq_pkg::ST_OK;
    r.value  = '0;
    r.prio   = '0;
    r.last   = 1'b1;
    op_count[op]++;
    if (op == sspq_pkg::OP_ENQUEUE) begin
      if (model_count >= CAP) begin
        r.status = sspq_pkg::ST_OVER;
        overflows++;
      end else begin
        // new entry goes behind every entry of equal or smaller priority
        pos = 0;
        while (pos < model_count && model_prio[pos] <= pri) pos++;
        for (int i = model_count; i > pos; i--) begin
          model_value[i] = model_value[i-1];
          model_prio[i]  = model_prio[i-1];
        end
        model_value[pos] = val;
        model_prio[pos]  = pri;
        model_count++;
        if (model_count > max_depth) max_depth = model_count;
      end
      pending_results.push_back(r);
    end else if (model_count == 0) begin
      r.status = sspq_pkg::ST_UNDER;
      underflows++;
      pending_results.push_back(r);
    end else if (op == sspq_pkg::OP_LIST) begin
      for (int i = 0; i < model_count; i++) begin
        r.value = model_value[i];
        r.prio  = model_prio[i];
        r.last  = (i == model_count - 1);
        pending_results.push_back(r);
      end
    end else begin
      r.value = model_value[0];
      r.prio  = model_prio[0];
      pending_results.push_back(r);
      if (op == sspq_pkg::OP_DEQUEUE) begin
        for (int i = 1; i < model_count; i++) begin
          model_value[i-1] = model_value[i];
          model_prio[i-1]  = model_prio[i];
        end
        model_count--;
      end
    end
  endtask

  // One command transaction; random hold-off before raising start.
  task automatic send_cmd(input sspq_pkg::op_t op, input value_t val, input prio_t pri);
    int gap;
    if (!steady && $urandom_range(0, 99) < 24) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    cmd_op    <= op;
    cmd_value <= val;
    cmd_prio  <= pri;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_queue_results(op, val, pri);
  endtask

  task automatic wait_results_done();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input queue_res_t exp_r);
    mismatches++;
    if (mismatches <= 10)
      $display({"[%0t] %s: exp st=%0d val=%h pri=%h last=%0b, ",
                "got st=%0d val=%h pri=%h last=%0b"},
               $realtime, what, exp_r.status, exp_r.value, exp_r.prio, exp_r.last,
               out_status, out_value_res, out_priority_res, out_last);
  endtask

  // Result checker: results cannot be stalled, so every strobe is one expected result.
  always @(posedge clk) begin
    queue_res_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        exp_r = '0;
        report_mismatch("unexpected result", exp_r);
      end else begin
        exp_r = pending_results.pop_front();
        results_checked++;
        if ({out_status, out_value_res, out_priority_res, out_last} !==
            {exp_r.status, exp_r.value, exp_r.prio, exp_r.last})
          report_mismatch("result mismatch", exp_r);
      end
    end
  end

  function automatic prio_t rand_prio();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return 16'h8000;
    if (sel < 10) return 16'h7fff;
    if (sel < 55) return prio_t'($urandom_range(0, 6) - 3);   // narrow band, many ties
    return prio_t'($urandom);
  endfunction

  function automatic value_t rand_value();
    case ($urandom_range(0, 39))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // phase 0 fills toward overflow, phase 1 drains toward underflow, 2 is mixed
  function automatic sspq_pkg::op_t pick_op(input int phase);
    int r;
    int enq_lim;
    int deq_lim;
    r = $urandom_range(0, 99);
    case (phase)
      0:       begin enq_lim = 70; deq_lim = 80; end
      1:       begin enq_lim = 15; deq_lim = 75; end
      default: begin enq_lim = 40; deq_lim = 70; end
    endcase
    if (r < enq_lim) return sspq_pkg::OP_ENQUEUE;
    if (r < deq_lim) return sspq_pkg::OP_DEQUEUE;
    if (r < deq_lim + (100 - deq_lim) / 2) return sspq_pkg::OP_PEEK;
    return sspq_pkg::OP_LIST;
  endfunction

  task automatic test_empty_queue();
    send_cmd(sspq_pkg::OP_DEQUEUE, 32'h1234_5678, 16'h0001);
    send_cmd(sspq_pkg::OP_PEEK, 32'hffff_ffff, 16'hffff);
    send_cmd(sspq_pkg::OP_LIST, 32'h0, 16'h8000);
  endtask

  // fill to capacity with ties and extremes, overflow once, then read back
  task automatic test_fill_and_order();
    int d_prio [16] = '{5, -32768, 32767, 5, 0, 5, -32768, 32767,
                        -1, 1, 0, 100, -100, 5, 32767, -32768};
    int d_val  [16] = '{32'h7fffffff, 32'h80000000, 0, -1, 1, 2, 3, 4,
                        5, 6, 7, 8, 9, 10, 11, 12};
    for (int i = 0; i < 16; i++)
      send_cmd(sspq_pkg::OP_ENQUEUE, value_t'(d_val[i]), prio_t'(d_prio[i]));
    send_cmd(sspq_pkg::OP_ENQUEUE, 32'h5555_5555, 16'h0000);
    send_cmd(sspq_pkg::OP_PEEK, 32'h0, 16'h0);
    send_cmd(sspq_pkg::OP_LIST, 32'h0, 16'h0);
    send_cmd(sspq_pkg::OP_DEQUEUE, 32'h0, 16'h0);
    send_cmd(sspq_pkg::OP_DEQUEUE, 32'h0, 16'h0);
    wait_results_done();
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < 350; i++) begin
      steady = (i >= 140 && i < 210);
      send_cmd(pick_op((i / 50) % 3), rand_value(), rand_prio());
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_fill_and_order();
    test_random_traffic();
    wait_results_done();

    $display("Commands: %0d enqueue, %0d dequeue, %0d peek, %0d list; %0d results checked",
             op_count[sspq_pkg::OP_ENQUEUE], op_count[sspq_pkg::OP_DEQUEUE],
             op_count[sspq_pkg::OP_PEEK], op_count[sspq_pkg::OP_LIST], results_checked);
    $display("Overflows %0d, underflows %0d, deepest queue %0d, mismatches %0d",
             overflows, underflows, max_depth, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
